// ===== rtl/amat_pkg.sv =====
// amat_pkg: shared types and codes for the active max/argmax tree block.
// Holds command codes, the controller state type and the req/rsp word types.
// No dependencies; compiled first.
package amat_pkg;

	// Fixed widths of the req/rsp word fields
	localparam int CMD_FW = 2;
	localparam int IDX_FW = 10;
	localparam int VAL_FW = 48;
	localparam int CNT_FW = 16;
	localparam int DLT_FW = 8;

	// Command codes (anything else behaves as a query)
	localparam logic [CMD_FW-1:0] CMD_LOAD   = 2'd0;
	localparam logic [CMD_FW-1:0] CMD_ADJUST = 2'd1;
	localparam logic [CMD_FW-1:0] CMD_QUERY  = 2'd2;

	typedef struct packed {
		logic [CMD_FW-1:0]        command;
		logic [IDX_FW-1:0]        entry_index;
		logic signed [VAL_FW-1:0] entry_value;
		logic [CNT_FW-1:0]        count_value;
		logic signed [DLT_FW-1:0] count_delta;
	} req_word_t;

	typedef struct packed {
		logic signed [VAL_FW-1:0] max_value;
		logic [IDX_FW-1:0]        max_index;
		logic                     empty_res;
		logic                     count_clipped;
	} rsp_word_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_QUERY,
		ST_LEAF,
		ST_CLIMB,
		ST_DONE
	} state_t;

endpackage

// ===== rtl/amat_stream_if.sv =====
// amat_stream_if: valid/ready channel carrying one word of a given type.
// Used for the req and rsp channels of the max/argmax tree; word types
// come from amat_pkg.
interface amat_stream_if #(
	parameter type word_t = logic
);
	logic  valid;
	logic  ready;
	word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/active_max_argmax_tree.sv =====
// active_max_argmax_tree: max value and lowest argmax over active entries.
// A load/adjust passes through the states LEAF, CLIMB and DONE before the rsp word is
// loaded; a query passes through QUERY and DONE. One word in flight: req.ready is high only
// in IDLE, so the next word is taken only after the last result is loaded into the rsp
// register; the climb does one tree level per cycle. Reset: a clearing sweep over every
// tree node zeroes the count and tree memories; req.ready stays low until it finishes.
module active_max_argmax_tree #(
	parameter int ENTRIES     = 1024,
	parameter int VALUE_WIDTH = 48,
	parameter int COUNT_WIDTH = 16
) (
	input logic            clk,
	input logic            arst_n,
	amat_stream_if.sink    req,
	amat_stream_if.source  rsp
);

	localparam int IW     = $clog2(ENTRIES);
	localparam int LEAVES = 1 << IW;
	localparam int NW     = IW + 1;
	localparam int SUMW   = ((COUNT_WIDTH > amat_pkg::CNT_FW) ? COUNT_WIDTH
	                                                          : amat_pkg::CNT_FW) + 2;
	localparam logic signed [SUMW-1:0] CMAX = SUMW'((64'd1 << COUNT_WIDTH) - 64'd1);
	localparam logic signed [63:0] VHI = (64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1;
	localparam logic signed [63:0] VLO = -VHI - 64'sd1;
	localparam logic [NW-1:0] ROOT = NW'(1);

	typedef struct packed {
		logic                          act;
		logic signed [VALUE_WIDTH-1:0] val;
		logic [IW-1:0]                 idx;
	} node_t;

	// Memories: heap-ordered tree (leaves at LEAVES+i) and per-entry counts
	node_t                  tree_mem [2*LEAVES];
	logic [COUNT_WIDTH-1:0] cnt_mem  [LEAVES];

	logic                   tree_we;
	logic [NW-1:0]          tree_wa;
	node_t                  tree_wd;
	logic [NW-1:0]          tree_ra;
	node_t                  tree_rd_q;
	logic                   cnt_we;
	logic [IW-1:0]          cnt_wa;
	logic [COUNT_WIDTH-1:0] cnt_wd;
	logic [IW-1:0]          cnt_ra;
	logic [COUNT_WIDTH-1:0] cnt_rd_q;

	// Control and captured word
	amat_pkg::state_t              state_q, state_d;
	logic [NW-1:0]                 clr_q;
	logic [IW-1:0]                 idx_q;
	logic                          load_q;
	logic signed [VALUE_WIDTH-1:0] val_q;
	logic [amat_pkg::CNT_FW-1:0]   cnt_ld_q;
	logic signed [amat_pkg::DLT_FW-1:0] delta_q;
	logic [NW-1:0]                 node_q;
	node_t                         cur_q;
	logic                          clip_q;
	logic                          out_valid_q;
	amat_pkg::rsp_word_t           out_word_q;

	logic                          req_ready;
	logic                          out_load;
	logic                          cmd_upd;
	logic signed [63:0]            val_ext;
	logic signed [63:0]            val_cl;
	logic signed [SUMW-1:0]        cnt_ext, ld_ext, dl_ext, sum_s, new_s;
	logic                          clip_d;
	logic [COUNT_WIDTH-1:0]        new_cnt;
	node_t                         leaf_w;
	node_t                         lft, rgt, comb;
	logic [NW-1:0]                 parent;
	logic signed [VALUE_WIDTH-1:0] res_val;

	// Tree memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (tree_we) begin
			tree_mem[tree_wa] <= tree_wd;
		end
		tree_rd_q <= tree_mem[tree_ra];
	end

	// Count memory
	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_wa] <= cnt_wd;
		end
		cnt_rd_q <= cnt_mem[cnt_ra];
	end

	// Decode of the incoming word
	always_comb begin
		cmd_upd = (req.data.command == amat_pkg::CMD_LOAD ||
		           req.data.command == amat_pkg::CMD_ADJUST) &&
		          (32'(req.data.entry_index) < 32'(ENTRIES));
		val_ext = 64'(req.data.entry_value);
		if (val_ext > VHI) begin
			val_cl = VHI;
		end else if (val_ext < VLO) begin
			val_cl = VLO;
		end else begin
			val_cl = val_ext;
		end
	end

	// Leaf update: saturating count and new leaf node
	always_comb begin
		cnt_ext = SUMW'(cnt_rd_q);
		ld_ext  = SUMW'(cnt_ld_q);
		dl_ext  = SUMW'(delta_q);
		sum_s   = cnt_ext + dl_ext;
		clip_d  = 1'b0;
		if (load_q) begin
			if (ld_ext > CMAX) begin
				new_s  = CMAX;
				clip_d = 1'b1;
			end else begin
				new_s = ld_ext;
			end
		end else if (sum_s < 0) begin
			new_s  = '0;
			clip_d = 1'b1;
		end else if (sum_s > CMAX) begin
			new_s  = CMAX;
			clip_d = 1'b1;
		end else begin
			new_s = sum_s;
		end
		new_cnt    = COUNT_WIDTH'(new_s);
		leaf_w.act = (new_cnt != '0);
		leaf_w.val = load_q ? val_q : tree_rd_q.val;
		leaf_w.idx = idx_q;
	end

	// Climb step: merge current node with its sibling, left wins ties
	always_comb begin
		lft    = node_q[0] ? tree_rd_q : cur_q;
		rgt    = node_q[0] ? cur_q : tree_rd_q;
		comb   = (lft.act && (!rgt.act || ($signed(lft.val) >= $signed(rgt.val)))) ? lft : rgt;
		parent = {1'b0, node_q[NW-1:1]};
	end

	// Next state and memory controls
	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		out_load  = 1'b0;
		tree_we   = 1'b0;
		tree_wa   = parent;
		tree_wd   = comb;
		tree_ra   = ROOT;
		cnt_we    = 1'b0;
		cnt_wa    = idx_q;
		cnt_wd    = new_cnt;
		cnt_ra    = IW'(req.data.entry_index);
		case (state_q)
			amat_pkg::ST_CLEAR: begin
				tree_we = 1'b1;
				tree_wa = clr_q;
				tree_wd = '0;
				cnt_we  = 1'b1;
				cnt_wa  = clr_q[IW-1:0];
				cnt_wd  = '0;
				if (clr_q == '1) begin
					state_d = amat_pkg::ST_IDLE;
				end
			end
			amat_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				tree_ra   = cmd_upd ? {1'b1, IW'(req.data.entry_index)} : ROOT;
				if (req.valid) begin
					state_d = cmd_upd ? amat_pkg::ST_LEAF : amat_pkg::ST_QUERY;
				end
			end
			amat_pkg::ST_QUERY: begin
				state_d = amat_pkg::ST_DONE;
			end
			amat_pkg::ST_LEAF: begin
				cnt_we  = 1'b1;
				tree_we = 1'b1;
				tree_wa = {1'b1, idx_q};
				tree_wd = leaf_w;
				tree_ra = {1'b1, idx_q ^ IW'(1)};
				state_d = amat_pkg::ST_CLIMB;
			end
			amat_pkg::ST_CLIMB: begin
				tree_we = 1'b1;
				tree_ra = parent ^ NW'(1);
				if (parent == ROOT) begin
					state_d = amat_pkg::ST_DONE;
				end
			end
			amat_pkg::ST_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = amat_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = amat_pkg::ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= amat_pkg::ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == amat_pkg::ST_CLEAR) begin
				clr_q <= clr_q + NW'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (req_ready && req.valid) begin
			idx_q    <= IW'(req.data.entry_index);
			load_q   <= (req.data.command == amat_pkg::CMD_LOAD);
			val_q    <= VALUE_WIDTH'(val_cl);
			cnt_ld_q <= req.data.count_value;
			delta_q  <= req.data.count_delta;
			clip_q   <= 1'b0;
		end
		case (state_q)
			amat_pkg::ST_QUERY: begin
				cur_q <= tree_rd_q;
			end
			amat_pkg::ST_LEAF: begin
				cur_q  <= leaf_w;
				node_q <= {1'b1, idx_q};
				clip_q <= clip_d;
			end
			amat_pkg::ST_CLIMB: begin
				cur_q  <= comb;
				node_q <= parent;
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_word_q.max_value     <= cur_q.act ? amat_pkg::VAL_FW'(res_val) : '0;
			out_word_q.max_index     <= cur_q.act ? amat_pkg::IDX_FW'(cur_q.idx) : '0;
			out_word_q.empty_res     <= !cur_q.act;
			out_word_q.count_clipped <= clip_q;
		end
	end

	assign res_val   = cur_q.val;
	assign req.ready = req_ready;
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_word_q;

	// Checks
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == amat_pkg::ST_LEAF || state_q == amat_pkg::ST_CLIMB) |-> tree_wa != tree_ra)
		else $error("tree write and read hit the same node");

	a_climb_below_root: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == amat_pkg::ST_CLIMB |-> node_q >= NW'(2))
		else $error("climb started from the root");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.data.empty_res) |->
		(rsp.data.max_index == '0 && rsp.data.max_value == '0))
		else $error("empty word carries a value or index");

	a_query_no_clip: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == amat_pkg::ST_QUERY |-> !clip_q)
		else $error("query flagged a clipped count");

	a_clear_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == amat_pkg::ST_CLEAR && clr_q == '1) |=> state_q == amat_pkg::ST_IDLE)
		else $error("clearing sweep did not finish");

endmodule

// ===== sim/testbench.sv =====
// testbench: self-checking bench for active_max_argmax_tree (max/argmax over active entries).
// Depends on amat_pkg and amat_stream_if from the rtl folder; drives req, checks rsp words
// against an in-bench table model with random idling on both channels.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ENTRIES = 1024;
	localparam int CNT_MAX = (1 << amat_pkg::CNT_FW) - 1;
	localparam logic [amat_pkg::CMD_FW-1:0] CMD_UNKNOWN = 2'd3;
	localparam logic signed [amat_pkg::VAL_FW-1:0] VAL_TOP =
		{1'b0, {(amat_pkg::VAL_FW-1){1'b1}}};
	localparam logic signed [amat_pkg::VAL_FW-1:0] VAL_BOT =
		{1'b1, {(amat_pkg::VAL_FW-1){1'b0}}};
	localparam int RANDOM_WORDS = 390;

	typedef struct {
		amat_pkg::req_word_t word;
		bit                  drain;   // hold this word until every result is back
	} stim_t;

	logic clk;
	logic arst_n;

	amat_stream_if #(.word_t(amat_pkg::req_word_t)) req_if ();
	amat_stream_if #(.word_t(amat_pkg::rsp_word_t)) rsp_if ();

	active_max_argmax_tree i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// Table model state
	logic signed [amat_pkg::VAL_FW-1:0] tbl_value [ENTRIES];
	logic [amat_pkg::CNT_FW-1:0]        tbl_count [ENTRIES];

	stim_t               word_queue[$];
	amat_pkg::rsp_word_t pending_results[$];
	int                  mismatch_count;

	// Generator-side record of which entries hold a written value
	bit        gen_loaded [ENTRIES];
	int        loaded_list[$];

	int  req_gap;
	int  rsp_stall;
	bit  send_calm;
	bit  recv_calm;
	bit  req_taken;
	bit  rsp_taken;

	// Clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic report_fail(string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// Apply one command to the table, then find the largest active value, lowest index on tie
	function automatic amat_pkg::rsp_word_t apply_to_table(amat_pkg::req_word_t w);
		amat_pkg::rsp_word_t r;
		int                  n;
		bit                  found;
		r = '0;
		if (int'(w.entry_index) < ENTRIES) begin
			case (w.command)
				amat_pkg::CMD_LOAD: begin
					tbl_value[w.entry_index] = w.entry_value;
					tbl_count[w.entry_index] = w.count_value;
				end
				amat_pkg::CMD_ADJUST: begin
					n = int'(tbl_count[w.entry_index]) + int'(w.count_delta);
					if (n < 0) begin
						n = 0;
						r.count_clipped = 1'b1;
					end else if (n > CNT_MAX) begin
						n = CNT_MAX;
						r.count_clipped = 1'b1;
					end
					tbl_count[w.entry_index] = n[amat_pkg::CNT_FW-1:0];
				end
				default: ;
			endcase
		end
		found = 1'b0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (tbl_count[i] != '0 && (!found || tbl_value[i] > r.max_value)) begin
				found = 1'b1;
				r.max_value = tbl_value[i];
				r.max_index = 10'(i);
			end
		end
		r.empty_res = !found;
		return r;
	endfunction

	// Idle length per word; occasionally flips into a no-idle stretch and back
	function automatic int draw_wait(inout bit calm);
		if ($urandom_range(0, 39) == 0)
			calm = !calm;
		return calm ? 0 : $urandom_range(0, 18);
	endfunction

	function automatic logic signed [amat_pkg::VAL_FW-1:0] rnd_value();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		return raw[amat_pkg::VAL_FW-1:0];
	endfunction

	task automatic queue_word(logic [amat_pkg::CMD_FW-1:0] cmd,
			logic [amat_pkg::IDX_FW-1:0] idx,
			logic signed [amat_pkg::VAL_FW-1:0] val, logic [amat_pkg::CNT_FW-1:0] cnt,
			logic signed [amat_pkg::DLT_FW-1:0] dlt, bit drain);
		stim_t s;
		s.word.command     = cmd;
		s.word.entry_index = idx;
		s.word.entry_value = val;
		s.word.count_value = cnt;
		s.word.count_delta = dlt;
		s.drain            = drain;
		if (cmd == amat_pkg::CMD_LOAD && !gen_loaded[idx]) begin
			gen_loaded[idx] = 1'b1;
			loaded_list.push_back(int'(idx));
		end
		word_queue.push_back(s);
	endtask

	// Sample both channels at the rising edge: predict on req accept, check on rsp accept
	always @(posedge clk) begin : watch
		amat_pkg::rsp_word_t got;
		amat_pkg::rsp_word_t want;
		req_taken = 1'b0;
		rsp_taken = 1'b0;
		if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready) begin
				rsp_taken = 1'b1;
				got = rsp_if.data;
				if (pending_results.size() == 0) begin
					report_fail($sformatf("result word %h with nothing outstanding", got));
				end else begin
					want = pending_results.pop_front();
					if (got.max_value !== want.max_value)
						report_fail($sformatf("max_value got %0d expected %0d",
							got.max_value, want.max_value));
					if (got.max_index !== want.max_index)
						report_fail($sformatf("max_index got %0d expected %0d",
							got.max_index, want.max_index));
					if (got.empty_res !== want.empty_res)
						report_fail($sformatf("empty_res got %b expected %b",
							got.empty_res, want.empty_res));
					if (got.count_clipped !== want.count_clipped)
						report_fail($sformatf("count_clipped got %b expected %b",
							got.count_clipped, want.count_clipped));
				end
			end
			if (req_if.valid && req_if.ready) begin
				req_taken = 1'b1;
				pending_results.push_back(apply_to_table(req_if.data));
			end
		end
	end

	// Request driver: one word at a time from word_queue, random gap after each accept
	always @(negedge clk) begin
		if (arst_n) begin
			if (req_taken)
				req_gap = draw_wait(send_calm);
			if (req_if.valid && !req_taken) begin
				// word still waiting for ready
			end else if (req_gap > 0) begin
				req_if.valid <= 1'b0;
				req_gap--;
			end else if (word_queue.size() == 0 ||
					(word_queue[0].drain && pending_results.size() != 0)) begin
				req_if.valid <= 1'b0;
			end else begin
				req_if.data  <= word_queue[0].word;
				req_if.valid <= 1'b1;
				void'(word_queue.pop_front());
			end
		end
	end

	// Response side: random stall after each taken word
	always @(negedge clk) begin
		if (arst_n) begin
			if (rsp_taken)
				rsp_stall = draw_wait(recv_calm);
			if (rsp_stall > 0) begin
				rsp_if.ready <= 1'b0;
				rsp_stall--;
			end else begin
				rsp_if.ready <= 1'b1;
			end
		end
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin : main
		logic [amat_pkg::IDX_FW-1:0]        hot [16];
		logic [amat_pkg::CMD_FW-1:0]        cmd;
		logic [amat_pkg::IDX_FW-1:0]        idx;
		logic signed [amat_pkg::VAL_FW-1:0] val;
		logic [amat_pkg::CNT_FW-1:0]        cnt;
		logic signed [amat_pkg::DLT_FW-1:0] dlt;
		int                                 pick;
		int                                 s;
		bit                                 first;

		req_if.valid   = 1'b0;
		req_if.data    = '0;
		rsp_if.ready   = 1'b0;
		arst_n         = 1'b0;
		mismatch_count = 0;
		req_gap        = 0;
		rsp_stall      = 0;
		send_calm      = 1'b0;
		recv_calm      = 1'b0;
		req_taken      = 1'b0;
		rsp_taken      = 1'b0;
		for (int i = 0; i < ENTRIES; i++) begin
			tbl_value[i]  = '0;
			tbl_count[i]  = '0;
			gen_loaded[i] = 1'b0;
		end

		// Directed: empty table, unknown command, clipping both ways, ties, extremes
		queue_word(amat_pkg::CMD_QUERY, 10'd0, rnd_value(), 16'($urandom), 8'($urandom), 1'b0);
		queue_word(CMD_UNKNOWN, 10'($urandom), rnd_value(), 16'($urandom), 8'($urandom), 1'b0);
		// adjusts on never-loaded entries that keep the count at zero
		queue_word(amat_pkg::CMD_ADJUST, 10'd5, rnd_value(), 16'($urandom), -8'sd128, 1'b0);
		queue_word(amat_pkg::CMD_ADJUST, 10'd1023, rnd_value(), 16'($urandom), 8'sd0, 1'b0);
		queue_word(amat_pkg::CMD_LOAD, 10'd1023, VAL_TOP, 16'hFFFF, 8'($urandom), 1'b0);
		queue_word(amat_pkg::CMD_ADJUST, 10'd1023, rnd_value(), 16'($urandom), 8'sd127, 1'b0);
		queue_word(amat_pkg::CMD_LOAD, 10'd0, VAL_BOT, 16'd1, 8'($urandom), 1'b0);
		queue_word(amat_pkg::CMD_LOAD, 10'd512, VAL_TOP, 16'd3, 8'($urandom), 1'b0);
		queue_word(amat_pkg::CMD_LOAD, 10'd7, VAL_TOP, 16'd0, 8'($urandom), 1'b0);
		queue_word(amat_pkg::CMD_ADJUST, 10'd7, rnd_value(), 16'($urandom), 8'sd1, 1'b0);
		queue_word(amat_pkg::CMD_ADJUST, 10'd7, rnd_value(), 16'($urandom), -8'sd128, 1'b0);
		queue_word(amat_pkg::CMD_ADJUST, 10'd1023, rnd_value(), 16'($urandom), -8'sd128,
			1'b0);
		queue_word(amat_pkg::CMD_QUERY, 10'($urandom), rnd_value(), 16'($urandom),
			8'($urandom), 1'b0);
		queue_word(amat_pkg::CMD_LOAD, 10'd1023, VAL_TOP, 16'd0, 8'($urandom), 1'b0);
		queue_word(amat_pkg::CMD_LOAD, 10'd512, rnd_value(), 16'd0, 8'($urandom), 1'b0);
		queue_word(amat_pkg::CMD_ADJUST, 10'd0, rnd_value(), 16'($urandom), -8'sd1, 1'b0);
		queue_word(amat_pkg::CMD_LOAD, 10'h2AA, 48'sh5555_5555_5555, 16'h5555, 8'h55, 1'b0);
		queue_word(amat_pkg::CMD_LOAD, 10'h155, 48'shAAAA_AAAA_AAAA, 16'hAAAA, 8'hAA, 1'b0);
		queue_word(amat_pkg::CMD_ADJUST, 10'h155, 48'sh5555_5555_5555, 16'h5555, 8'h55, 1'b0);
		queue_word(amat_pkg::CMD_ADJUST, 10'h2AA, 48'shAAAA_AAAA_AAAA, 16'hAAAA, 8'hAA, 1'b0);
		queue_word(CMD_UNKNOWN, 10'h3FF, VAL_BOT, 16'hFFFF, 8'hFF, 1'b0);

		// Random: mostly a small working set so ties, clipping and re-activation recur
		for (int i = 0; i < 16; i++)
			hot[i] = 10'($urandom);
		hot[0] = 10'd0;
		hot[1] = 10'd1023;
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			// once midway, deactivate everything loaded so far
			if (n == RANDOM_WORDS / 2) begin
				first = 1'b1;
				foreach (loaded_list[k]) begin
					queue_word(amat_pkg::CMD_LOAD, 10'(loaded_list[k]), rnd_value(), 16'd0,
						8'($urandom), first);
					first = 1'b0;
				end
			end
			pick = $urandom_range(0, 99);
			if (pick < 40)
				cmd = amat_pkg::CMD_LOAD;
			else if (pick < 80)
				cmd = amat_pkg::CMD_ADJUST;
			else if (pick < 92)
				cmd = amat_pkg::CMD_QUERY;
			else
				cmd = CMD_UNKNOWN;
			idx = ($urandom_range(0, 9) < 7) ? hot[$urandom_range(0, 15)] : 10'($urandom);
			pick = $urandom_range(0, 9);
			if (pick < 4) begin
				s = $urandom_range(0, 8);
				val = 48'(s - 4);
			end else if (pick < 6) begin
				val = $urandom_range(0, 1) ? VAL_TOP : VAL_BOT;
			end else begin
				val = rnd_value();
			end
			case ($urandom_range(0, 3))
				0: cnt = '0;
				1: cnt = 16'($urandom_range(1, 3));
				2: cnt = 16'(CNT_MAX - $urandom_range(0, 200));
				default: cnt = 16'($urandom);
			endcase
			dlt = 8'($urandom);
			// an unwritten entry may only see adjusts that leave its count at zero
			if (cmd == amat_pkg::CMD_ADJUST && !gen_loaded[idx] && dlt > 0)
				dlt = -dlt;
			queue_word(cmd, idx, val, cnt, dlt, n == 0 || $urandom_range(0, 59) == 0);
		end

		// Reset, released at a falling edge
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (word_queue.size() != 0 || req_if.valid)
			@(negedge clk);
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (30) @(negedge clk);
		if (pending_results.size() != 0)
			report_fail($sformatf("%0d results never arrived", pending_results.size()));
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
